>>> rtl/scc_count_kosaraju_top_assert.svh
// ----------------------------------------------------------------------------
// Assertion macros for the SCC counter
// Shared concurrent assertion forms, clocked on clk_i, off during reset.
// ----------------------------------------------------------------------------
`ifndef SCC_COUNT_KOSARAJU_TOP_ASSERT_SVH
`define SCC_COUNT_KOSARAJU_TOP_ASSERT_SVH

// check that an expression holds at every clock edge
`define SCC_ASSERT_ALWAYS(lbl, expr, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (expr)) else $error(msg);

// check that a condition implies a consequence in the same cycle
`define SCC_ASSERT_IMPLY(lbl, cond, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (cond) |-> (cons)) \
    else $error(msg);

`endif

>>> rtl/scc_pkg.sv
// ----------------------------------------------------------------------------
// SCC counter package
// Sizes, codes and shared types of the strongly connected component counter.
// ----------------------------------------------------------------------------
package scc_pkg;

  localparam int unsigned MAX_VERTICES = 64;
  localparam int unsigned MAX_EDGES    = 256;

  localparam int unsigned VW = $clog2(MAX_VERTICES);
  localparam int unsigned CW = $clog2(MAX_VERTICES + 1);
  localparam int unsigned EW = $clog2(MAX_EDGES);
  localparam int unsigned HW = $clog2(MAX_EDGES + 1);

  typedef enum logic [1:0] {
    OP_ADD     = 2'd0,
    OP_COMPUTE = 2'd1,
    OP_CLEAR   = 2'd2,
    OP_RSVD    = 2'd3
  } op_e;

  typedef enum logic [1:0] {
    STAT_DONE  = 2'd0,
    STAT_FULL  = 2'd1,
    STAT_RANGE = 2'd2
  } status_e;

  typedef struct packed {
    logic [VW-1:0] src;
    logic [VW-1:0] dst;
  } edge_t;

  typedef struct packed {
    logic [VW-1:0] vertex;
    logic [HW-1:0] next_edge;
  } frame_t;

  typedef struct packed {
    logic busy;
    logic done;
  } eng_stat_t;

endpackage

>>> rtl/scc_ram.sv
// ----------------------------------------------------------------------------
// Generic RAM
// One write port, one read port, read data registered.
// ----------------------------------------------------------------------------
module scc_ram #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 64
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_o <= mem_q[raddr_i];
  end

endmodule

>>> rtl/scc_engine.sv
// ----------------------------------------------------------------------------
// SCC walk engine
// Two depth-first passes over the edge store with a frame stack in RAM.
// ----------------------------------------------------------------------------
`include "scc_count_kosaraju_top_assert.svh"

module scc_engine import scc_pkg::*; (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          start_i,
  input  logic [CW-1:0] n_i,
  input  logic [HW-1:0] held_i,
  output logic [EW-1:0] edge_raddr_o,
  input  edge_t         edge_rdata_i,
  output eng_stat_t     stat_o,
  output logic [CW-1:0] count_o
);

  typedef enum logic [10:0] {
    S_IDLE = 11'b00000000001,
    S_CLR  = 11'b00000000010,
    S_P1RD = 11'b00000000100,
    S_P1CK = 11'b00000001000,
    S_P2RD = 11'b00000010000,
    S_P2VS = 11'b00000100000,
    S_P2CK = 11'b00001000000,
    S_WRD  = 11'b00010000000,
    S_WCK  = 11'b00100000000,
    S_WVS  = 11'b01000000000,
    S_WPOP = 11'b10000000000
  } state_e;

  state_e                  st_q, st_d;
  logic                    pass_q, pass_d;
  logic [CW-1:0]           i_q, i_d;
  logic [VW-1:0]           top_v_q, top_v_d;
  logic [HW-1:0]           top_e_q, top_e_d;
  logic [CW-1:0]           sp_q, sp_d;
  logic [CW-1:0]           flen_q, flen_d;
  logic [CW-1:0]           cnt_q, cnt_d;
  logic                    done;

  logic          stk_we;
  logic [VW-1:0] stk_waddr, stk_raddr;
  frame_t        stk_wdata, stk_rdata;
  logic          fin_we;
  logic [VW-1:0] fin_raddr;
  logic [VW-1:0] fin_rdata;
  logic          vis_we;
  logic [VW-1:0] vis_waddr, vis_raddr;
  logic          vis_wdata, vis_rdata;

  logic [VW-1:0] u, w;
  logic          cand;

  assign u = pass_q ? edge_rdata_i.dst : edge_rdata_i.src;
  assign w = pass_q ? edge_rdata_i.src : edge_rdata_i.dst;
  assign cand = (u == top_v_q) && (CW'(w) < n_i) && (sp_q < CW'(MAX_VERTICES));

  always_comb begin
    st_d         = st_q;
    pass_d       = pass_q;
    i_d          = i_q;
    top_v_d      = top_v_q;
    top_e_d      = top_e_q;
    sp_d         = sp_q;
    flen_d       = flen_q;
    cnt_d        = cnt_q;
    done         = 1'b0;
    stk_we       = 1'b0;
    stk_waddr    = VW'(sp_q - CW'(1));
    stk_wdata    = '{vertex: top_v_q, next_edge: top_e_q + HW'(1)};
    stk_raddr    = VW'(sp_q - CW'(2));
    fin_we       = 1'b0;
    fin_raddr    = VW'(i_q - CW'(1));
    vis_we       = 1'b0;
    vis_waddr    = i_q[VW-1:0];
    vis_wdata    = 1'b1;
    vis_raddr    = i_q[VW-1:0];
    edge_raddr_o = top_e_q[EW-1:0];
    unique case (st_q)
      S_IDLE: begin
        if (start_i) begin
          flen_d = '0;
          cnt_d  = '0;
          i_d    = '0;
          pass_d = 1'b0;
          st_d   = S_CLR;
        end
      end
      S_CLR: begin
        vis_we    = 1'b1;
        vis_wdata = 1'b0;
        if (i_q == CW'(MAX_VERTICES - 1)) begin
          if (pass_q) begin
            i_d  = flen_q;
            st_d = S_P2RD;
          end else begin
            i_d  = '0;
            st_d = S_P1RD;
          end
        end else begin
          i_d = i_q + CW'(1);
        end
      end
      S_P1RD: begin
        if (i_q >= n_i) begin
          pass_d = 1'b1;
          i_d    = '0;
          st_d   = S_CLR;
        end else begin
          st_d = S_P1CK;
        end
      end
      S_P1CK: begin
        if (!vis_rdata) begin
          vis_we  = 1'b1;
          top_v_d = i_q[VW-1:0];
          top_e_d = '0;
          sp_d    = CW'(1);
          st_d    = S_WRD;
        end else begin
          i_d  = i_q + CW'(1);
          st_d = S_P1RD;
        end
      end
      S_P2RD: begin
        if (i_q == '0) begin
          done = 1'b1;
          st_d = S_IDLE;
        end else begin
          st_d = S_P2VS;
        end
      end
      S_P2VS: begin
        vis_raddr = fin_rdata;
        st_d      = S_P2CK;
      end
      S_P2CK: begin
        if ((CW'(fin_rdata) < n_i) && !vis_rdata) begin
          cnt_d     = cnt_q + CW'(1);
          vis_we    = 1'b1;
          vis_waddr = fin_rdata;
          top_v_d   = fin_rdata;
          top_e_d   = '0;
          sp_d      = CW'(1);
          st_d      = S_WRD;
        end else begin
          i_d  = i_q - CW'(1);
          st_d = S_P2RD;
        end
      end
      S_WRD: begin
        if (top_e_q >= held_i) begin
          if (!pass_q && (flen_q < CW'(MAX_VERTICES))) begin
            fin_we = 1'b1;
            flen_d = flen_q + CW'(1);
          end
          sp_d = sp_q - CW'(1);
          if (sp_q == CW'(1)) begin
            if (pass_q) begin
              i_d  = i_q - CW'(1);
              st_d = S_P2RD;
            end else begin
              i_d  = i_q + CW'(1);
              st_d = S_P1RD;
            end
          end else begin
            st_d = S_WPOP;
          end
        end else begin
          st_d = S_WCK;
        end
      end
      S_WCK: begin
        if (cand) begin
          vis_raddr = w;
          st_d      = S_WVS;
        end else begin
          top_e_d = top_e_q + HW'(1);
          st_d    = S_WRD;
        end
      end
      S_WVS: begin
        if (!vis_rdata) begin
          stk_we    = 1'b1;
          vis_we    = 1'b1;
          vis_waddr = w;
          top_v_d   = w;
          top_e_d   = '0;
          sp_d      = sp_q + CW'(1);
        end else begin
          top_e_d = top_e_q + HW'(1);
        end
        st_d = S_WRD;
      end
      S_WPOP: begin
        top_v_d = stk_rdata.vertex;
        top_e_d = stk_rdata.next_edge;
        st_d    = S_WRD;
      end
      default: st_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      st_q   <= S_IDLE;
      pass_q <= 1'b0;
      i_q    <= '0;
      sp_q   <= '0;
      flen_q <= '0;
      cnt_q  <= '0;
    end else begin
      st_q   <= st_d;
      pass_q <= pass_d;
      i_q    <= i_d;
      sp_q   <= sp_d;
      flen_q <= flen_d;
      cnt_q  <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    top_v_q <= top_v_d;
    top_e_q <= top_e_d;
  end

  scc_ram #(
    .WIDTH($bits(frame_t)),
    .DEPTH(MAX_VERTICES)
  ) u_stack (
    .clk_i  (clk_i),
    .we_i   (stk_we),
    .waddr_i(stk_waddr),
    .wdata_i(stk_wdata),
    .raddr_i(stk_raddr),
    .rdata_o(stk_rdata)
  );

  scc_ram #(
    .WIDTH(VW),
    .DEPTH(MAX_VERTICES)
  ) u_finish (
    .clk_i  (clk_i),
    .we_i   (fin_we),
    .waddr_i(flen_q[VW-1:0]),
    .wdata_i(top_v_q),
    .raddr_i(fin_raddr),
    .rdata_o(fin_rdata)
  );

  scc_ram #(
    .WIDTH(1),
    .DEPTH(MAX_VERTICES)
  ) u_visited (
    .clk_i  (clk_i),
    .we_i   (vis_we),
    .waddr_i(vis_waddr),
    .wdata_i(vis_wdata),
    .raddr_i(vis_raddr),
    .rdata_o(vis_rdata)
  );

  assign stat_o  = '{busy: (st_q != S_IDLE), done: done};
  assign count_o = cnt_q;

  `SCC_ASSERT_ALWAYS(a_sp_bound, sp_q <= CW'(MAX_VERTICES), "walk stack overflow")
  `SCC_ASSERT_IMPLY(a_pop_nonempty, st_q == S_WPOP, sp_q != '0, "pop from empty stack")
  `SCC_ASSERT_IMPLY(a_cnt_bound, done, cnt_q <= flen_q, "count exceeds finished vertices")

endmodule

>>> rtl/scc_count_kosaraju_top.sv
// Edge add, clear and dropped edge are handled on acceptance; a dropped edge's result appears the next cycle.
// Compute: two passes, each opening with a clear of all 64 visited marks, then the result.
// Throughput: one edge per cycle; ready is low during a compute or while a result waits.
// Reset clears the edge count, vertex count and engine state at once; no clearing pass.
// ----------------------------------------------------------------------------
// SCC counter top level
// Edge store, op decode and result register around the Kosaraju walk engine.
// ----------------------------------------------------------------------------
`include "scc_count_kosaraju_top_assert.svh"

module scc_count_kosaraju_top import scc_pkg::*; (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        cfg_we_i,
  input  logic [6:0]  cfg_wdata_i,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [15:0] s_axis_tdata,   // [5:0] edge_from, [11:6] edge_to, [15:12] zero
  input  logic [1:0]  s_axis_tuser,   // [1:0] op
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [7:0]  m_axis_tdata,   // [6:0] scc_count, [7] zero
  output logic [1:0]  m_axis_tuser    // [1:0] status
);

  logic [6:0]    vcnt_q;
  logic [CW-1:0] n;
  logic [HW-1:0] held_q, held_d;
  logic          ov_q, ov_d;
  logic [6:0]    ocnt_q, ocnt_d;
  status_e       ost_q, ost_d;

  logic          acc;
  logic [VW-1:0] from, to;
  logic          start;
  logic          ewe;
  edge_t         ewdata, erdata;
  logic [EW-1:0] eraddr;
  eng_stat_t     estat;
  logic [CW-1:0] ecount;

  assign n    = (vcnt_q > 7'(MAX_VERTICES)) ? CW'(MAX_VERTICES) : CW'(vcnt_q);
  assign from = s_axis_tdata[5:0];
  assign to   = s_axis_tdata[11:6];
  assign acc  = s_axis_tvalid && s_axis_tready;
  assign s_axis_tready = !estat.busy && (!ov_q || m_axis_tready);
  assign ewdata = '{src: from, dst: to};

  always_comb begin
    held_d = held_q;
    ov_d   = ov_q && !m_axis_tready;
    ocnt_d = ocnt_q;
    ost_d  = ost_q;
    start  = 1'b0;
    ewe    = 1'b0;
    if (estat.done) begin
      ov_d   = 1'b1;
      ocnt_d = 7'(ecount);
      ost_d  = STAT_DONE;
    end
    if (acc) begin
      unique case (op_e'(s_axis_tuser))
        OP_ADD: begin
          if ((CW'(from) >= n) || (CW'(to) >= n)) begin
            ov_d   = 1'b1;
            ocnt_d = '0;
            ost_d  = STAT_RANGE;
          end else if (held_q >= HW'(MAX_EDGES)) begin
            ov_d   = 1'b1;
            ocnt_d = '0;
            ost_d  = STAT_FULL;
          end else begin
            ewe    = 1'b1;
            held_d = held_q + HW'(1);
          end
        end
        OP_COMPUTE: start = 1'b1;
        OP_CLEAR:   held_d = '0;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vcnt_q <= '0;
      held_q <= '0;
      ov_q   <= 1'b0;
    end else begin
      if (cfg_we_i) begin
        vcnt_q <= cfg_wdata_i;
      end
      held_q <= held_d;
      ov_q   <= ov_d;
    end
  end

  always_ff @(posedge clk_i) begin
    ocnt_q <= ocnt_d;
    ost_q  <= ost_d;
  end

  scc_ram #(
    .WIDTH($bits(edge_t)),
    .DEPTH(MAX_EDGES)
  ) u_edges (
    .clk_i  (clk_i),
    .we_i   (ewe),
    .waddr_i(held_q[EW-1:0]),
    .wdata_i(ewdata),
    .raddr_i(eraddr),
    .rdata_o(erdata)
  );

  scc_engine u_engine (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .start_i     (start),
    .n_i         (n),
    .held_i      (held_q),
    .edge_raddr_o(eraddr),
    .edge_rdata_i(erdata),
    .stat_o      (estat),
    .count_o     (ecount)
  );

  assign m_axis_tvalid = ov_q;
  assign m_axis_tdata  = {1'b0, ocnt_q};
  assign m_axis_tuser  = ost_q;

  `SCC_ASSERT_ALWAYS(a_held_bound, held_q <= HW'(MAX_EDGES), "edge count overflow")
  `SCC_ASSERT_IMPLY(a_ready_idle, s_axis_tready, !estat.busy, "ready while engine busy")
  `SCC_ASSERT_IMPLY(a_done_free, estat.done, !ov_q || m_axis_tready, "result slot taken")

endmodule
